// ===== design/pdl_pkg.sv =====
// Shared types and constants for the PAL delay-line pixel pipeline.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package pdl_pkg;

  // Field widths.
  localparam int COL_W  = 9;
  localparam int IDX_W  = 8;
  localparam int BANK_W = 2;
  localparam int RGB_W  = 24;
  localparam int R565_W = 16;

  // Stream and register port widths.
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  // Item kinds carried in in_tuser.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Palette banks.
  localparam logic [BANK_W-1:0] BANK_EVEN   = 2'd0;
  localparam logic [BANK_W-1:0] BANK_ODD    = 2'd1;
  localparam logic [BANK_W-1:0] BANK_DIRECT = 2'd2;

  // Monitor modes.
  localparam logic [1:0] MON_COLOR = 2'd0;
  localparam logic [1:0] MON_GRAY  = 2'd1;
  localparam logic [1:0] MON_GREEN = 2'd2;
  localparam logic [1:0] MON_AMBER = 2'd3;

  // Register indexes (word address bits 3..2).
  localparam logic [1:0] REG_PAL_BLEND     = 2'd0;
  localparam logic [1:0] REG_MONITOR_MODE  = 2'd1;
  localparam logic [1:0] REG_VISIBLE_START = 2'd2;
  localparam logic [1:0] REG_VISIBLE_END   = 2'd3;

  // Register reset values.
  localparam logic       RST_PAL_BLEND     = 1'b1;
  localparam logic [1:0] RST_MONITOR_MODE  = MON_COLOR;
  localparam logic [8:0] RST_VISIBLE_START = 9'd24;
  localparam logic [8:0] RST_VISIBLE_END   = 9'd360;

  // Luma weights (per mille) and the reciprocal used for the divide by 125.
  localparam int LUMA_WR     = 299;
  localparam int LUMA_WG     = 587;
  localparam int LUMA_WB     = 114;
  localparam int RECIP_125   = 1048;  // floor(2^17 / 125)
  localparam int DIV_125     = 125;
  localparam int AMBER_G     = 176;
  localparam int HUE_MASK    = 8'hF0;
  localparam int LUMA_MASK   = 8'h0F;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic                   pal_blend;
    logic [1:0]             monitor_mode;
    logic [COL_W-1:0]       visible_start;
    logic [COL_W-1:0]       visible_end;
  } pdl_cfg_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic                   is_wr;
    logic [IDX_W-1:0]       idx;
    logic [IDX_W-1:0]       mixed;
    logic                   odd;
    logic                   vis;
    logic [BANK_W-1:0]      bank;
    logic [RGB_W-1:0]       rgb;
  } pdl_item_t;

endpackage

// ===== design/pal_delay_line_pixel_pipeline_top.sv =====
// Top level of the PAL delay-line pixel pipeline: register port, front end,
// queue and back end. Depends on pdl_pkg, pdl_front, pdl_queue, pdl_back.
`timescale 1ns / 1ps

// Usage
// The in_ stream carries one item per handshake. in_tuser says whether the
// item is a pixel or a palette entry write; in_tdata holds the remaining
// fields. A pixel item gives exactly one result item on the out_ stream
// (RGB565 in the low bits, RGB888 above it); a palette write gives none.
// Pixels must arrive in raster order so that the line buffer holds the
// previous line's indices when the next line is read.
// Throughput is one item per clock while out_tready is high, bounded by the
// single read and write port of the line buffer and of each palette memory.
// With no stall, a result passes from the front stage through one queue
// slot, six back stages and the output register before it appears on
// out_tvalid. When the receiver holds out_tready low, the back pipeline
// freezes and the four-entry queue keeps the front running until it fills,
// then in_tready drops. Reset clears all valid flags and the queue and
// loads the register defaults (PAL blend on, color mode, window 24..359).
// Palette and line buffer contents are undefined until written. The cfg_
// port always answers at once; the user must write registers only while
// the block is idle, as the block does not enforce it.
module pal_delay_line_pixel_pipeline_top #(
  parameter int LINE_WIDTH = 384
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // in_tdata from bit 0 up: color_index[7:0], column[16:8], first_line[17],
  // phase_odd[18], palette_bank[20:19], palette_rgb[44:21], zero fill.
  input  logic [pdl_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: cmd (0 pixel, 1 palette write).
  input  logic [pdl_pkg::IN_TUSER_W-1:0]  in_tuser,
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata from bit 0 up: rgb565[15:0], rgb888[39:16].
  output logic [pdl_pkg::OUT_TDATA_W-1:0] out_tdata,
  // Register port.
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [pdl_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [pdl_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [pdl_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                            cfg_pready
);
  import pdl_pkg::*;

  logic             pal_blend_r;
  logic [1:0]       monitor_mode_r;
  logic [COL_W-1:0] visible_start_r;
  logic [COL_W-1:0] visible_end_r;
  logic             cfg_wr;
  pdl_cfg_t         cfg;

  logic             fq_valid, fq_ready;
  pdl_item_t        fq_item;
  logic             qb_valid, qb_ready;
  pdl_item_t        qb_item;

  // Registers are addressed by word; the two low address bits are ignored.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_blend_r     <= RST_PAL_BLEND;
      monitor_mode_r  <= RST_MONITOR_MODE;
      visible_start_r <= RST_VISIBLE_START;
      visible_end_r   <= RST_VISIBLE_END;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_PAL_BLEND:     pal_blend_r     <= cfg_pwdata[0];
        REG_MONITOR_MODE:  monitor_mode_r  <= cfg_pwdata[1:0];
        REG_VISIBLE_START: visible_start_r <= cfg_pwdata[COL_W-1:0];
        REG_VISIBLE_END:   visible_end_r   <= cfg_pwdata[COL_W-1:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_PAL_BLEND:     cfg_prdata = CFG_DW'(pal_blend_r);
      REG_MONITOR_MODE:  cfg_prdata = CFG_DW'(monitor_mode_r);
      REG_VISIBLE_START: cfg_prdata = CFG_DW'(visible_start_r);
      REG_VISIBLE_END:   cfg_prdata = CFG_DW'(visible_end_r);
      default:           cfg_prdata = '0;
    endcase
  end

  always_comb begin
    cfg.pal_blend     = pal_blend_r;
    cfg.monitor_mode  = monitor_mode_r;
    cfg.visible_start = visible_start_r;
    cfg.visible_end   = visible_end_r;
  end

  // The front reads and updates the line buffer and tags each item with its
  // window flag and its blended palette address.
  pdl_front #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_tuser[0]),
    .in_idx   (in_tdata[7:0]),
    .in_col   (in_tdata[16:8]),
    .in_first (in_tdata[17]),
    .in_odd   (in_tdata[18]),
    .in_bank  (in_tdata[20:19]),
    .in_rgb   (in_tdata[44:21]),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_item   (fq_item)
  );

  pdl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  // The back applies palette writes in stream order, so a pixel that
  // follows a write always sees the new entry.
  pdl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (qb_valid),
    .in_ready  (qb_ready),
    .in_item   (qb_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

// ===== design/pdl_front.sv =====
// Front end: accepts items, keeps the previous-line index buffer and
// classifies each item for the back end. Depends on pdl_pkg.
`timescale 1ns / 1ps

module pdl_front #(
  parameter int LINE_WIDTH = 384
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pdl_pkg::pdl_cfg_t           cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_cmd,
  input  logic [pdl_pkg::IDX_W-1:0]   in_idx,
  input  logic [pdl_pkg::COL_W-1:0]   in_col,
  input  logic                        in_first,
  input  logic                        in_odd,
  input  logic [pdl_pkg::BANK_W-1:0]  in_bank,
  input  logic [pdl_pkg::RGB_W-1:0]   in_rgb,
  output logic                        q_valid,
  input  logic                        q_ready,
  output pdl_pkg::pdl_item_t          q_item
);
  import pdl_pkg::*;

  localparam int LB_AW = $clog2(LINE_WIDTH);
  localparam int CW    = (LB_AW > COL_W) ? LB_AW : COL_W;

  logic [IDX_W-1:0]  line_mem [LINE_WIDTH];
  logic [IDX_W-1:0]  lb_rd_r;

  logic              f1_valid_r;
  logic              f1_is_wr_r;
  logic [IDX_W-1:0]  f1_idx_r;
  logic              f1_use_prev_r;
  logic              f1_odd_r;
  logic              f1_vis_r;
  logic [BANK_W-1:0] f1_bank_r;
  logic [RGB_W-1:0]  f1_rgb_r;

  logic [CW-1:0]     col_ext;
  logic [LB_AW-1:0]  lb_addr;
  logic              in_line;
  logic              accept;
  logic              is_pixel;
  logic              vis;
  logic [IDX_W-1:0]  prev;

  assign col_ext  = CW'(in_col);
  assign lb_addr  = col_ext[LB_AW-1:0];
  assign in_line  = {1'b0, col_ext} < (CW+1)'(LINE_WIDTH);
  assign in_ready = !f1_valid_r || q_ready;
  assign accept   = in_valid && in_ready;
  assign is_pixel = (in_cmd == CMD_PIXEL);
  assign vis      = (in_col >= cfg.visible_start) && (in_col < cfg.visible_end);

  // The buffer read returns the index left by the previous line; the new
  // index replaces it at the same edge.
  always_ff @(posedge clk) begin
    if (accept && is_pixel && in_line) begin
      lb_rd_r           <= line_mem[lb_addr];
      line_mem[lb_addr] <= in_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (in_ready) begin
      f1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_is_wr_r    <= !is_pixel;
      f1_idx_r      <= in_idx;
      f1_use_prev_r <= in_line && !in_first;
      f1_odd_r      <= in_odd;
      f1_vis_r      <= vis;
      f1_bank_r     <= in_bank;
      f1_rgb_r      <= in_rgb;
    end
  end

  assign prev    = f1_use_prev_r ? lb_rd_r : f1_idx_r;
  assign q_valid = f1_valid_r;

  always_comb begin
    q_item.is_wr = f1_is_wr_r;
    q_item.idx   = f1_idx_r;
    q_item.mixed = (prev & IDX_W'(HUE_MASK)) | (f1_idx_r & IDX_W'(LUMA_MASK));
    q_item.odd   = f1_odd_r;
    q_item.vis   = f1_vis_r;
    q_item.bank  = f1_bank_r;
    q_item.rgb   = f1_rgb_r;
  end

endmodule

// ===== design/pdl_queue.sv =====
// Short first-in first-out queue that decouples the front from the back.
// Depends on pdl_pkg for the item type and the depth.
`timescale 1ns / 1ps

module pdl_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  pdl_pkg::pdl_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output pdl_pkg::pdl_item_t pop_item
);
  import pdl_pkg::*;

  pdl_item_t         q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push;
  logic              pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== design/pdl_back.sv =====
// Back end: palette memories, delay-line blend, monitor transform and the
// output register. Depends on pdl_pkg.
`timescale 1ns / 1ps

module pdl_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pdl_pkg::pdl_cfg_t               cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pdl_pkg::pdl_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pdl_pkg::OUT_TDATA_W-1:0] out_data
);
  import pdl_pkg::*;

  logic [RGB_W-1:0] even_mem [256];
  logic [RGB_W-1:0] odd_mem  [256];
  logic [RGB_W-1:0] dir_mem  [256];

  logic             adv;
  logic             pop;
  logic [IDX_W-1:0] even_addr;
  logic [IDX_W-1:0] odd_addr;

  // Stage 1: palette reads.
  logic             s1_v_r, s1_odd_r, s1_vis_r;
  logic [RGB_W-1:0] even_rd_r, odd_rd_r, dir_rd_r;
  // Stage 2: blended or direct color.
  logic             s2_v_r, s2_vis_r;
  logic [RGB_W-1:0] s2_rgb_r;
  // Stage 3: weighted channels.
  logic             s3_v_r, s3_vis_r;
  logic [RGB_W-1:0] s3_rgb_r;
  logic [16:0]      s3_pr_r;
  logic [17:0]      s3_pg_r;
  logic [14:0]      s3_pb_r;
  // Stage 4: weighted sum.
  logic             s4_v_r, s4_vis_r;
  logic [RGB_W-1:0] s4_rgb_r;
  logic [17:0]      s4_sum_r;
  // Stage 5: quotient estimate.
  logic             s5_v_r, s5_vis_r;
  logic [RGB_W-1:0] s5_rgb_r;
  logic [14:0]      s5_s8_r;
  logic [7:0]       s5_q_r;
  // Stage 6: corrected luma.
  logic             s6_v_r, s6_vis_r;
  logic [RGB_W-1:0] s6_rgb_r;
  logic [7:0]       s6_luma_r;
  // Output register.
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [RGB_W-1:0] pa, pb;
  logic [8:0]       sum_r8, sum_g8, sum_b8;
  logic [RGB_W-1:0] blend_rgb;
  logic [16:0]      pr;
  logic [17:0]      pg;
  logic [14:0]      pbw;
  logic [14:0]      s8;
  logic [25:0]      qprod;
  logic [14:0]      qx125;
  logic [14:0]      rem;
  logic [15:0]      amb_t;
  logic [16:0]      amb_s;
  logic [7:0]       amb_g;
  logic [RGB_W-1:0] mon_rgb;
  logic [R565_W-1:0] rgb565;

  // The whole back pipeline moves whenever the output register can take.
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign pop       = in_valid && adv;
  assign even_addr = in_item.odd ? in_item.mixed : in_item.idx;
  assign odd_addr  = in_item.odd ? in_item.idx : in_item.mixed;

  always_ff @(posedge clk) begin
    if (pop) begin
      even_rd_r <= even_mem[even_addr];
      odd_rd_r  <= odd_mem[odd_addr];
      dir_rd_r  <= dir_mem[in_item.idx];
      if (in_item.is_wr) begin
        case (in_item.bank)
          BANK_EVEN:   even_mem[in_item.idx] <= in_item.rgb;
          BANK_ODD:    odd_mem[in_item.idx]  <= in_item.rgb;
          BANK_DIRECT: dir_mem[in_item.idx]  <= in_item.rgb;
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= pop && !in_item.is_wr;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      s5_v_r      <= s4_v_r;
      s6_v_r      <= s5_v_r;
      out_valid_r <= s6_v_r;
    end
  end

  // Current-phase entry and opposite-phase entry, averaged per channel.
  assign pa        = s1_odd_r ? odd_rd_r : even_rd_r;
  assign pb        = s1_odd_r ? even_rd_r : odd_rd_r;
  assign sum_r8    = 9'(pa[23:16]) + 9'(pb[23:16]);
  assign sum_g8    = 9'(pa[15:8]) + 9'(pb[15:8]);
  assign sum_b8    = 9'(pa[7:0]) + 9'(pb[7:0]);
  assign blend_rgb = {sum_r8[8:1], sum_g8[8:1], sum_b8[8:1]};

  assign pr  = 17'(s2_rgb_r[23:16]) * 17'(LUMA_WR);
  assign pg  = 18'(s2_rgb_r[15:8]) * 18'(LUMA_WG);
  assign pbw = 15'(s2_rgb_r[7:0]) * 15'(LUMA_WB);

  // luma = sum / 1000 = (sum / 8) / 125; the reciprocal estimate is low by
  // at most one and the next stage corrects it.
  assign s8    = s4_sum_r[17:3];
  assign qprod = 26'(s8) * 26'(RECIP_125);
  assign qx125 = 15'(s5_q_r) * 15'(DIV_125);
  assign rem   = s5_s8_r - qx125;

  // Amber green = luma * 176 / 255, using x / 255 = (x + x / 256 + 1) / 256.
  assign amb_t = 16'(s6_luma_r) * 16'(AMBER_G);
  assign amb_s = 17'(amb_t) + 17'(amb_t[15:8]) + 17'd1;
  assign amb_g = amb_s[15:8];

  always_comb begin
    case (cfg.monitor_mode)
      MON_COLOR: mon_rgb = s6_rgb_r;
      MON_GRAY:  mon_rgb = {s6_luma_r, s6_luma_r, s6_luma_r};
      MON_GREEN: mon_rgb = {8'd0, s6_luma_r, 8'd0};
      MON_AMBER: mon_rgb = {s6_luma_r, amb_g, 8'd0};
      default:   mon_rgb = s6_rgb_r;
    endcase
    if (!s6_vis_r) begin
      mon_rgb = '0;
    end
    rgb565 = {mon_rgb[23:19], mon_rgb[15:10], mon_rgb[7:3]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_odd_r   <= in_item.odd;
      s1_vis_r   <= in_item.vis;
      s2_vis_r   <= s1_vis_r;
      s2_rgb_r   <= cfg.pal_blend ? blend_rgb : dir_rd_r;
      s3_vis_r   <= s2_vis_r;
      s3_rgb_r   <= s2_rgb_r;
      s3_pr_r    <= pr;
      s3_pg_r    <= pg;
      s3_pb_r    <= pbw;
      s4_vis_r   <= s3_vis_r;
      s4_rgb_r   <= s3_rgb_r;
      s4_sum_r   <= 18'(s3_pr_r) + s3_pg_r + 18'(s3_pb_r);
      s5_vis_r   <= s4_vis_r;
      s5_rgb_r   <= s4_rgb_r;
      s5_s8_r    <= s8;
      s5_q_r     <= qprod[24:17];
      s6_vis_r   <= s5_vis_r;
      s6_rgb_r   <= s5_rgb_r;
      s6_luma_r  <= (rem >= 15'(DIV_125)) ? s5_q_r + 8'd1 : s5_q_r;
      out_data_r <= {mon_rgb, rgb565};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
